// File: rtl/core/cel_pkg.sv
`timescale 1ns / 1ps
// cel_pkg: shared widths, action codes and the command word passed from
// the front end to the back end of csr_element_lookup. no dependencies.
package cel_pkg;

    // field widths of the input and result words
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 10;
    localparam int START_W  = 11;
    localparam int COLUMN_W = 8;
    localparam int BITS_W   = 64;
    localparam int ROW_W    = 8;
    localparam int POS_W    = 10;

    // parameter defaults
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_VALUE_WIDTH = 64;

    // command queue depth
    localparam int QUEUE_DEPTH = 2;

    // action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_LOAD_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ENTRY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY      = 2'd2;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_LOAD_START,
        CMD_LOAD_ENTRY,
        CMD_QUERY,
        CMD_QUERY_MISS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SLOT_W-1:0]   slot;
        logic [START_W-1:0]  start_value;
        logic [COLUMN_W-1:0] entry_column;
        logic [BITS_W-1:0]   entry_bits;
        logic [ROW_W-1:0]    query_row;
        logic [COLUMN_W-1:0] query_column;
    } cmd_t;

endpackage

// File: rtl/core/cel_front.sv
`timescale 1ns / 1ps
// cel_front: accepts input words and classifies them into commands,
// dropping unused actions and out-of-range loads. depends on cel_pkg.
module cel_front #(
    parameter int MAX_ROWS    = cel_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = cel_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cel_pkg::ACTION_W-1:0]  action,
    input  logic [cel_pkg::SLOT_W-1:0]    slot,
    input  logic [cel_pkg::START_W-1:0]   start_value,
    input  logic [cel_pkg::COLUMN_W-1:0]  entry_column,
    input  logic [cel_pkg::BITS_W-1:0]    entry_bits,
    input  logic [cel_pkg::ROW_W-1:0]     query_row,
    input  logic [cel_pkg::COLUMN_W-1:0]  query_column,
    input  logic                          q_full,
    output logic                          push,
    output cel_pkg::cmd_t                 cmd
);

    logic keep;

    assign in_ready = !q_full;

    always_comb
    begin
        keep     = 1'b0;
        cmd.kind = cel_pkg::CMD_QUERY_MISS;
        unique case (action)
            cel_pkg::ACT_LOAD_START:
            begin
                keep     = (32'(slot) <= 32'(MAX_ROWS));
                cmd.kind = cel_pkg::CMD_LOAD_START;
            end
            cel_pkg::ACT_LOAD_ENTRY:
            begin
                keep     = (32'(slot) < 32'(MAX_ENTRIES));
                cmd.kind = cel_pkg::CMD_LOAD_ENTRY;
            end
            cel_pkg::ACT_QUERY:
            begin
                keep     = 1'b1;
                // rows past the table answer a miss without touching memory
                cmd.kind = (32'(query_row) < 32'(MAX_ROWS)) ?
                           cel_pkg::CMD_QUERY : cel_pkg::CMD_QUERY_MISS;
            end
            default:
            begin
                keep     = 1'b0;
                cmd.kind = cel_pkg::CMD_QUERY_MISS;
            end
        endcase
        cmd.slot         = slot;
        cmd.start_value  = start_value;
        cmd.entry_column = entry_column;
        cmd.entry_bits   = entry_bits;
        cmd.query_row    = query_row;
        cmd.query_column = query_column;
    end

    assign push = in_valid && !q_full && keep;

endmodule

// File: rtl/core/cel_queue.sv
`timescale 1ns / 1ps
// cel_queue: short command fifo between front and back end.
// depends on cel_pkg.
module cel_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cel_pkg::cmd_t push_cmd,
    input  logic          pop,
    output cel_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);

    localparam int PW = (cel_pkg::QUEUE_DEPTH > 1) ? $clog2(cel_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(cel_pkg::QUEUE_DEPTH + 1);

    cel_pkg::cmd_t slot_reg [cel_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(cel_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(cel_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(cel_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/cel_back.sv
`timescale 1ns / 1ps
// cel_back: executes commands against the row start, column and value
// memories, scans rows one entry a cycle, holds the result word. depends on cel_pkg.
module cel_back #(
    parameter int MAX_ROWS    = cel_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = cel_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_WIDTH = cel_pkg::DEF_VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cel_pkg::cmd_t                head_cmd,
    input  logic                         q_empty,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [cel_pkg::POS_W-1:0]    position,
    output logic [cel_pkg::BITS_W-1:0]   value_bits
);

    localparam int RA = $clog2(MAX_ROWS + 1);
    localparam int EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = cel_pkg::START_W;
    localparam int CW = cel_pkg::COLUMN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_EMIT
    } state_t;

    logic [SW-1:0]          row_mem [MAX_ROWS + 1];
    logic [CW-1:0]          col_mem [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] val_mem [MAX_ENTRIES];

    logic [SW-1:0]          row_rdata_reg;
    logic [CW-1:0]          col_rdata_reg;
    logic [VALUE_WIDTH-1:0] val_rdata_reg;

    state_t                 state_reg, state_next;
    logic [cel_pkg::ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [SW-1:0]          first_reg, first_next;
    logic [SW-1:0]          last_reg, last_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic                   hit_reg, hit_next;
    logic [cel_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [cel_pkg::BITS_W-1:0] bits_reg, bits_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [cel_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [cel_pkg::BITS_W-1:0] out_bits_reg, out_bits_next;

    logic [RA-1:0]          row_raddr;
    logic [EA-1:0]          ent_raddr;
    logic                   row_we, ent_we;
    logic [SW-1:0]          last_clip;
    logic [SW-1:0]          idx_inc;
    logic                   can_emit;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign row_we   = pop && (head_cmd.kind == cel_pkg::CMD_LOAD_START);
    assign ent_we   = pop && (head_cmd.kind == cel_pkg::CMD_LOAD_ENTRY);
    assign can_emit = !out_valid_reg || out_ready;
    assign idx_inc  = idx_reg + 1'b1;

    // row end is limited to the entry store
    assign last_clip = (32'(row_rdata_reg) > 32'(MAX_ENTRIES)) ?
                       SW'(MAX_ENTRIES) : row_rdata_reg;

    // read addresses: row start at row then row + 1; entries from first on
    assign row_raddr = (state_reg == ST_FIRST) ?
                       RA'({1'b0, row_reg} + 9'd1) : RA'(head_cmd.query_row);
    assign ent_raddr = (state_reg == ST_LAST) ? EA'(first_reg) : EA'(idx_inc);

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[RA'(head_cmd.slot)] <= head_cmd.start_value;
        end
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            col_mem[EA'(head_cmd.slot)] <= head_cmd.entry_column;
            val_mem[EA'(head_cmd.slot)] <= head_cmd.entry_bits[VALUE_WIDTH-1:0];
        end
        col_rdata_reg <= col_mem[ent_raddr];
        val_rdata_reg <= val_mem[ent_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_bits_next  = out_bits_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    row_next = head_cmd.query_row;
                    col_next = head_cmd.query_column;
                    hit_next  = 1'b0;
                    pos_next  = '0;
                    bits_next = '0;
                    if (head_cmd.kind == cel_pkg::CMD_QUERY)
                    begin
                        state_next = ST_FIRST;
                    end
                    else if (head_cmd.kind == cel_pkg::CMD_QUERY_MISS)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FIRST:
            begin
                first_next = row_rdata_reg;
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                last_next = last_clip;
                idx_next  = first_reg;
                state_next = (first_reg >= last_clip) ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (col_rdata_reg == col_reg)
                begin
                    hit_next   = 1'b1;
                    pos_next   = cel_pkg::POS_W'(idx_reg);
                    bits_next  = cel_pkg::BITS_W'(val_rdata_reg);
                    state_next = ST_EMIT;
                end
                else if (idx_inc >= last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_pos_next   = pos_reg;
                    out_bits_next  = bits_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            pos_reg       <= '0;
            bits_reg      <= '0;
            out_found_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_bits_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            bits_reg      <= bits_next;
            out_found_reg <= out_found_next;
            out_pos_reg   <= out_pos_next;
            out_bits_reg  <= out_bits_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign position   = out_pos_reg;
    assign value_bits = out_bits_reg;

endmodule

// File: rtl/core/csr_element_lookup.sv
`timescale 1ns / 1ps
// csr_element_lookup: top level of the sparse matrix element lookup.
// instantiates cel_front, cel_queue and cel_back; depends on cel_pkg.
//
// channel | handshake           | word
// --------+---------------------+---------------------------------------------
// input   | in_valid, in_ready  | action, slot, start_value, entry_column,
//         |                     | entry_bits, query_row, query_column
// output  | out_valid, out_ready| found, position, value_bits
//
// an accepted word is registered in the command queue before the back end
// takes it. a load is written to its memory as it is taken from the queue. a
// query is taken from the queue, reads the row start of row and row + 1, scans
// the row's entries one per cycle through the single read port of the
// column/value memories until the match or the row end, and then emits. a
// query on a row past the table goes straight from the queue to emit.
// rst_n is asynchronous; it clears control state only, the memories hold
// nothing defined until written. the two-deep command queue lets the front
// keep accepting words while the back end scans; a result that is not taken
// holds the back end in emit, and in_ready drops once the queue is full.
module csr_element_lookup #(
    parameter int MAX_ROWS    = cel_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = cel_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_WIDTH = cel_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cel_pkg::ACTION_W-1:0]  action,
    input  logic [cel_pkg::SLOT_W-1:0]    slot,
    input  logic [cel_pkg::START_W-1:0]   start_value,
    input  logic [cel_pkg::COLUMN_W-1:0]  entry_column,
    input  logic [cel_pkg::BITS_W-1:0]    entry_bits,
    input  logic [cel_pkg::ROW_W-1:0]     query_row,
    input  logic [cel_pkg::COLUMN_W-1:0]  query_column,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [cel_pkg::POS_W-1:0]     position,
    output logic [cel_pkg::BITS_W-1:0]    value_bits
);

    // front to queue
    cel_pkg::cmd_t push_cmd;
    logic          push;
    logic          q_full;

    // queue to back
    cel_pkg::cmd_t head_cmd;
    logic          q_empty;
    logic          pop;

    // classification: drops unused actions and out-of-range loads,
    // marks queries on rows past the table as misses
    cel_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .slot         (slot),
        .start_value  (start_value),
        .entry_column (entry_column),
        .entry_bits   (entry_bits),
        .query_row    (query_row),
        .query_column (query_column),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    // in-order command queue keeps loads and queries in sequence
    cel_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // memories, row scan and result register
    cel_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .value_bits (value_bits)
    );

endmodule
